FILE: rtl/kct_pkg.sv
`timescale 1ns / 1ps

package kct_pkg;

    // operating modes, codes match the reported mode field
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_SEC   = 3'd1,
        MODE_MIN   = 3'd2,
        MODE_RUN   = 3'd3,
        MODE_ALARM = 3'd4
    } t_mode;

    // event kinds
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_KEY  = 1'b1;

    // key codes
    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [3:0] KEY_A         = 4'd10;
    localparam logic [3:0] KEY_B         = 4'd11;
    localparam logic [3:0] KEY_C         = 4'd12;
    localparam logic [3:0] KEY_D         = 4'd13;

    localparam logic [5:0] TIME_LIMIT  = 6'd59;
    localparam logic [6:0] ENTRY_LIMIT = 7'd59;

    typedef struct packed {
        logic       opcode;
        logic [3:0] key_code;
    } t_in_item;

    typedef struct packed {
        logic [3:0] min_tens;
        logic [3:0] min_units;
        logic [3:0] sec_tens;
        logic [3:0] sec_units;
        logic       buzzer_on;
        logic [2:0] mode_now;
        logic       entry_error;
    } t_out_item;

    // updated timer state handed from the core to the display formatter
    typedef struct packed {
        t_mode      mode;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [3:0] first_digit;
        logic       digits_taken;
        logic       entry_error;
    } t_core_view;

    // tens digit of a value below 64: multiply by 13, drop 7 bits
    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [9:0] prod;
        prod = {4'd0, v} * 10'd13;
        return prod[9:7] == 3'd0 ? 4'd0 : {1'b0, prod[9:7]};
    endfunction

    // units digit of a value below 64
    function automatic logic [3:0] units_of(input logic [5:0] v);
        logic [3:0] t;
        logic [5:0] rem;
        t   = tens_of(v);
        rem = v - ({2'd0, t} * 6'd10);
        return rem[3:0];
    endfunction

endpackage

FILE: rtl/kct_core.sv
`timescale 1ns / 1ps

module kct_core
    import kct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_in_item   i_item,
    output t_core_view o_view
);

    t_mode      r_mode,         n_mode;
    logic [5:0] r_minutes,      n_minutes;
    logic [5:0] r_seconds,      n_seconds;
    logic [3:0] r_first_digit,  n_first_digit;
    logic       r_digits_taken, n_digits_taken;
    logic       n_err;

    logic       is_key;
    logic       is_digit;
    logic [6:0] entry_val;

    assign is_key    = (i_item.opcode == OP_KEY);
    assign is_digit  = is_key && (i_item.key_code <= KEY_DIGIT_MAX);
    assign entry_val = ({3'd0, r_first_digit} * 7'd10) + {3'd0, i_item.key_code};

    // state registers, updated once per event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_IDLE;
            r_minutes      <= 6'd0;
            r_seconds      <= 6'd0;
            r_first_digit  <= 4'd0;
            r_digits_taken <= 1'b0;
        end else if (i_step) begin
            r_mode         <= n_mode;
            r_minutes      <= n_minutes;
            r_seconds      <= n_seconds;
            r_first_digit  <= n_first_digit;
            r_digits_taken <= n_digits_taken;
        end
    end

    // next state for one event
    always_comb begin
        n_mode         = r_mode;
        n_minutes      = r_minutes;
        n_seconds      = r_seconds;
        n_first_digit  = r_first_digit;
        n_digits_taken = r_digits_taken;
        n_err          = 1'b0;
        unique case (r_mode)
            MODE_SEC, MODE_MIN: begin
                if (is_digit) begin
                    if (!r_digits_taken) begin
                        n_first_digit  = i_item.key_code;
                        n_digits_taken = 1'b1;
                    end else begin
                        n_first_digit  = 4'd0;
                        n_digits_taken = 1'b0;
                        if (entry_val > ENTRY_LIMIT) begin
                            n_err = 1'b1;
                        end else begin
                            if (r_mode == MODE_SEC) begin
                                n_seconds = entry_val[5:0];
                            end else begin
                                n_minutes = entry_val[5:0];
                            end
                            n_mode = MODE_IDLE;
                        end
                    end
                end
            end
            MODE_RUN: begin
                if (!is_key) begin
                    // count down one second, borrow from minutes
                    if (r_seconds == 6'd0) begin
                        n_seconds = TIME_LIMIT;
                        if (r_minutes != 6'd0) begin
                            n_minutes = r_minutes - 6'd1;
                        end
                    end else begin
                        n_seconds = r_seconds - 6'd1;
                    end
                    if (n_minutes == 6'd0 && n_seconds == 6'd0) begin
                        n_mode = MODE_ALARM;
                    end
                end
            end
            MODE_ALARM: begin
                n_minutes = 6'd0;
                n_seconds = 6'd0;
                if (is_key && i_item.key_code == KEY_B) begin
                    n_mode = MODE_IDLE;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
                if (is_key) begin
                    priority if (i_item.key_code == KEY_D) begin
                        n_mode         = MODE_SEC;
                        n_first_digit  = 4'd0;
                        n_digits_taken = 1'b0;
                    end else if (i_item.key_code == KEY_C) begin
                        n_mode         = MODE_MIN;
                        n_first_digit  = 4'd0;
                        n_digits_taken = 1'b0;
                    end else if (i_item.key_code == KEY_A) begin
                        n_mode = (r_minutes == 6'd0 && r_seconds == 6'd0) ?
                                 MODE_ALARM : MODE_RUN;
                    end else begin
                        n_mode = MODE_IDLE;
                    end
                end
            end
        endcase
    end

    assign o_view = '{
        mode:         n_mode,
        minutes:      n_minutes,
        seconds:      n_seconds,
        first_digit:  n_first_digit,
        digits_taken: n_digits_taken,
        entry_error:  n_err
    };

endmodule

FILE: rtl/kct_fmt.sv
`timescale 1ns / 1ps

module kct_fmt
    import kct_pkg::*;
(
    input  t_core_view i_view,
    output t_out_item  o_result
);

    logic [3:0] entry_digit;

    // field under entry shows the first digit once taken, zero before
    assign entry_digit = i_view.digits_taken ? i_view.first_digit : 4'd0;

    always_comb begin
        o_result.min_tens    = tens_of(i_view.minutes);
        o_result.min_units   = units_of(i_view.minutes);
        o_result.sec_tens    = tens_of(i_view.seconds);
        o_result.sec_units   = units_of(i_view.seconds);
        o_result.buzzer_on   = (i_view.mode == MODE_ALARM);
        o_result.mode_now    = i_view.mode;
        o_result.entry_error = i_view.entry_error;
        if (i_view.mode == MODE_SEC) begin
            o_result.sec_tens  = entry_digit;
            o_result.sec_units = 4'd0;
        end else if (i_view.mode == MODE_MIN) begin
            o_result.min_tens  = entry_digit;
            o_result.min_units = 4'd0;
        end
    end

endmodule

FILE: rtl/keypad_countdown_timer.sv
`timescale 1ns / 1ps

// Minutes:seconds countdown timer with alarm. Each input beat is either a
// one-second tick or a decoded key press, and each produces exactly one
// result beat with the four display digits, buzzer, mode and entry error.
// D starts seconds entry, C minutes entry (two digits, values above 59 are
// flagged and entry restarts), A runs the countdown, B silences the alarm.
// An event is captured in an input register, the state update and digit
// split are combinational, and the result sits in an output register, so a
// new beat is taken every cycle unless o_stall holds it. o_stall rises only
// while both registers are full and i_stall holds.

module keypad_countdown_timer
    import kct_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_item,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_item o_result,
    input  logic      i_stall
);

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;

    logic       out_free;
    logic       step;
    logic       in_load;
    t_core_view view;
    t_out_item  result;

    // pipeline flow control
    assign out_free = !r_out_valid || !i_stall;
    assign step     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_load  = i_valid && !o_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_item <= i_item;
        end
    end

    kct_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in_item),
        .o_view  (view)
    );

    kct_fmt u_fmt (
        .i_view   (view),
        .o_result (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item <= result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out_item;

    // alarm always shows 0:00
    a_alarm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.buzzer_on) |->
        (o_result.min_tens == 4'd0 && o_result.min_units == 4'd0 &&
         o_result.sec_tens == 4'd0 && o_result.sec_units == 4'd0))
        else $error("alarm result with nonzero time");

    // a rejection only happens while an entry is open
    a_err_in_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.entry_error) |->
        (o_result.mode_now == MODE_SEC || o_result.mode_now == MODE_MIN))
        else $error("entry error outside entry mode");

    // every digit is decimal
    a_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
        (o_result.min_tens <= 4'd9 && o_result.min_units <= 4'd9 &&
         o_result.sec_tens <= 4'd9 && o_result.sec_units <= 4'd9))
        else $error("non-decimal digit on display");

    // a stepped event always lands in the result register
    a_step_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("event lost between input and result registers");

endmodule
